### rtl/core/aes256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_pkg
// Shared types, constants and GF(2^8) helpers for the AES-256 pipeline.
// ----------------------------------------------------------------------------
package aes256_pkg;

    localparam int NUM_ROUNDS = 14;
    localparam int KEY_REGS   = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 2'd3;

    typedef logic [127:0] t_block;
    typedef logic [255:0] t_key;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

### rtl/core/aes256_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_stream_if
// Valid/ready channel carrying one 128-bit block as two 64-bit words.
// ----------------------------------------------------------------------------
interface aes256_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;

    modport source (output valid, output data_high, output data_low, input ready);
    modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

### rtl/core/aes256_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_round
// One pipeline stage: a cipher round plus one 128-bit step of the key schedule.
// ----------------------------------------------------------------------------
module aes256_round #(
    parameter int ROUND = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  aes256_pkg::t_block i_state,
    input  aes256_pkg::t_key   i_key,
    output logic               o_valid,
    output aes256_pkg::t_block o_state,
    output aes256_pkg::t_key   o_key
);
    import aes256_pkg::*;

    // rcon for odd rounds: 2^((ROUND-1)/2)
    localparam logic [7:0] RCON = 8'(1 << ((ROUND - 1) / 2));
    localparam bit         ODD  = (ROUND % 2) == 1;
    localparam bit         LAST = (ROUND == NUM_ROUNDS);

    logic [31:0]  w [8];
    logic [31:0]  nw [4];
    logic [31:0]  t;
    logic [7:0]   s [16];
    logic [7:0]   m [16];
    t_block       rk;
    t_block       n_state;
    t_key         n_key;
    logic         r_valid;
    t_block       r_state;
    t_key         r_key;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w[i] = i_key[255 - 32*i -: 32];
        end
        // round key for this round is the lower half of the window
        rk = i_key[127:0];
        if (ODD) begin
            t = sub_word({w[7][23:0], w[7][31:24]}) ^ {RCON, 24'h0};
        end else begin
            t = sub_word(w[7]);
        end
        nw[0] = w[0] ^ t;
        for (int i = 1; i < 4; i++) begin
            nw[i] = w[i] ^ nw[i-1];
        end
        n_key = {i_key[127:0], nw[0], nw[1], nw[2], nw[3]};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                s[4*c+r] = SBOX[i_state[127 - 8*(4*((c+r)%4)+r) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] all;
            all = s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
            for (int r = 0; r < 4; r++) begin
                m[4*c+r] = LAST ? s[4*c+r]
                                : s[4*c+r] ^ all ^ xtime(s[4*c+r] ^ s[4*c+((r+1)%4)]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            n_state[127 - 8*i -: 8] = m[i];
        end
        n_state = n_state ^ rk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

### rtl/core/aes256_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_block_encrypt
// AES-256 encryption pipeline: 15 stages, one block per cycle unless the output stalls.
// A transaction passes through stage 0 and then every round stage before its result is valid.
// Throughput: one transaction per cycle unless the output stalls; each round stage owns its S-boxes.
// Reset: i_rst_n synchronous active low; clears key registers and valid bits.
// ----------------------------------------------------------------------------
module aes256_block_encrypt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [aes256_pkg::CFG_IDX_W:0] i_cfg_idx,
    input  logic [63:0]                    i_cfg_data,
    aes256_stream_if.sink                  s_in,
    aes256_stream_if.source                m_out
);
    import aes256_pkg::*;

    // Key registers; index 4..7 are ignored.
    logic [63:0] r_key [KEY_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_REGS; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we && !i_cfg_idx[CFG_IDX_W]) begin
            unique case (i_cfg_idx[CFG_IDX_W-1:0])
                REG_KEY_WORD_0: r_key[0] <= i_cfg_data;
                REG_KEY_WORD_1: r_key[1] <= i_cfg_data;
                REG_KEY_WORD_2: r_key[2] <= i_cfg_data;
                REG_KEY_WORD_3: r_key[3] <= i_cfg_data;
                default:        r_key[0] <= r_key[0];
            endcase
        end
    end

    // Whole pipe advances together; a bubble-free stall is fine at this rate.
    logic en;
    assign en = m_out.ready | ~m_out.valid;
    assign s_in.ready = en;

    // Stage 0: initial AddRoundKey, key window = key words 0..7.
    logic   r_valid0;
    t_block r_state0;
    t_key   r_kwin0;
    t_key   key_all;
    assign key_all = {r_key[0], r_key[1], r_key[2], r_key[3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (en) begin
            r_valid0 <= s_in.valid;
        end
        if (en) begin
            r_state0 <= {s_in.data_high, s_in.data_low} ^ key_all[255:128];
            r_kwin0  <= key_all;
        end
    end

    // Stage r: round r. Its key is the lower half of the incoming window.
    logic   v   [NUM_ROUNDS+1];
    t_block st  [NUM_ROUNDS+1];
    t_key   kw  [NUM_ROUNDS+1];

    assign v[0]  = r_valid0;
    assign st[0] = r_state0;
    assign kw[0] = r_kwin0;

    // Window into round r holds round keys r-1 and r; every stage derives the
    // next round key and shifts it into the window.
    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
        aes256_round #(.ROUND(g)) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g-1]),
            .i_state (st[g-1]),
            .i_key   (kw[g-1]),
            .o_valid (v[g]),
            .o_state (st[g]),
            .o_key   (kw[g])
        );
    end

    assign m_out.valid     = v[NUM_ROUNDS];
    assign m_out.data_high = st[NUM_ROUNDS][127:64];
    assign m_out.data_low  = st[NUM_ROUNDS][63:0];

endmodule
